@@ hdl/fab_pkg.sv @@
// fab_pkg: shared types and constants for the fit block allocator
// request and response payloads, fit modes, controller states, register map
// no dependencies
`timescale 1ns / 1ps

package fab_pkg;

    localparam int BLOCKS_DEF    = 8;
    localparam int SIZE_BITS_DEF = 16;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    localparam logic [3:0] COUNT_RESET = 4'd8;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_WORST = 2'd1,
        FIT_NEXT  = 2'd2
    } fab_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUT
    } fab_state_t;

    typedef struct packed {
        logic        command;
        logic [2:0]  block_index;
        logic [15:0] amount;
    } fab_req_t;

    typedef struct packed {
        logic        granted;
        logic [2:0]  chosen_block;
        logic [15:0] left_in_block;
    } fab_rsp_t;

    // scan record flags carried from cell to cell
    typedef struct packed {
        logic tok;
        logic found;
        logic ahead;
    } fab_flags_t;

endpackage

@@ hdl/fab_cell.sv @@
// fab_cell: one table entry of the allocator chain
// holds one free size and updates the passing scan record one hop per cycle
// depends on fab_pkg
`timescale 1ns / 1ps

module fab_cell
    import fab_pkg::*;
#(
    parameter int BLOCKS    = BLOCKS_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF,
    parameter int CELL_IDX  = 0
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [1:0]                 mode,
    input  logic [$clog2(BLOCKS)-1:0]  start,
    input  logic                       in_use,
    input  logic [SIZE_BITS-1:0]       req,
    input  logic                       wr_en,
    input  logic [SIZE_BITS-1:0]       wr_data,
    input  fab_flags_t                 flags_in,
    input  logic [$clog2(BLOCKS)-1:0]  idx_in,
    input  logic [SIZE_BITS-1:0]       size_in,
    output fab_flags_t                 flags_out,
    output logic [$clog2(BLOCKS)-1:0]  idx_out,
    output logic [SIZE_BITS-1:0]       size_out
);

    localparam int IDX_W = $clog2(BLOCKS);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [SIZE_BITS-1:0] free_reg, free_next;
    fab_flags_t           flags_reg, flags_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic                 fits;
    logic                 ahead_here;
    logic                 take;

    assign fits       = in_use && (free_reg >= req);
    assign ahead_here = MY_IDX >= start;

    always_comb begin
        case (mode)
            FIT_WORST: take = fits && (!flags_in.found || (size_in < free_reg));
            FIT_NEXT:  take = fits && (!flags_in.found || (!flags_in.ahead && ahead_here));
            default:   take = fits && !flags_in.found;
        endcase
    end

    always_comb begin
        free_next        = wr_en ? wr_data : free_reg;
        flags_next.tok   = flags_in.tok;
        flags_next.found = flags_in.found || take;
        flags_next.ahead = take ? ahead_here : flags_in.ahead;
        idx_next         = take ? MY_IDX : idx_in;
        size_next        = take ? free_reg : size_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_reg  <= '0;
            flags_reg <= '0;
        end else begin
            free_reg  <= free_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        size_reg <= size_next;
    end

    assign flags_out = flags_reg;
    assign idx_out   = idx_reg;
    assign size_out  = size_reg;

endmodule

@@ hdl/fit_block_allocator.sv @@
// fit_block_allocator: top level, controller, config registers and cell chain
// depends on fab_pkg and fab_cell
//
//  channel  ports            payload     direction
//  request  s_valid/s_ready  fab_req_t   in
//  result   m_valid/m_ready  fab_rsp_t   out
//  config   psel..pready     32 bit APB  in/out
//
// a load: entry and result register written on acceptance, then put, then idle
// an allocate: scan through the chain, write-back of the winner, then put, then idle
// the scan record walks the cell chain one cell a cycle, then the winner is written back
// one request is in flight at a time; the result register frees the input side
// reset clears the table, pointer and registers at once, no clearing pass
// a stalled result holds in the output register and the finished result behind it
`timescale 1ns / 1ps

module fit_block_allocator
    import fab_pkg::*;
#(
    parameter int BLOCKS    = BLOCKS_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fab_req_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output fab_rsp_t          m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int IDX_W = $clog2(BLOCKS);

    fab_state_t           state_reg, state_next;
    logic [1:0]           mode_reg, mode_next;
    logic [3:0]           count_reg, count_next;
    logic [IDX_W-1:0]     next_ptr_reg, next_ptr_next;
    logic                 launch_reg, launch_next;
    logic [SIZE_BITS-1:0] req_reg, req_next;
    logic [IDX_W-1:0]     start_reg, start_next;
    fab_rsp_t             res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    fab_rsp_t             m_data_reg, m_data_next;

    logic                 in_acc;
    logic                 cfg_wr;
    logic                 put_go;
    logic                 finish;
    logic                 fin_found;
    logic [IDX_W-1:0]     fin_idx;
    logic [SIZE_BITS-1:0] fin_size;
    logic [SIZE_BITS-1:0] left_full;
    logic [SIZE_BITS-1:0] amt;
    logic [SIZE_BITS-1:0] wr_data;

    fab_flags_t           flag_c [0:BLOCKS];
    logic [IDX_W-1:0]     idx_c  [0:BLOCKS];
    logic [SIZE_BITS-1:0] size_c [0:BLOCKS];
    logic [BLOCKS-1:0]    use_mask;
    logic [BLOCKS-1:0]    wr_en;

    assign in_acc    = s_valid && s_ready;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign amt       = SIZE_BITS'(s_data.amount);
    assign finish    = flag_c[BLOCKS].tok;
    assign fin_found = flag_c[BLOCKS].found;
    assign fin_idx   = idx_c[BLOCKS];
    assign fin_size  = size_c[BLOCKS];
    assign left_full = fin_size - req_reg;
    assign wr_data   = (state_reg == ST_SCAN) ? left_full : amt;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = (s_data.command == CMD_ALLOC) ? ST_SCAN : ST_PUT;
                end
            end
            ST_SCAN: begin
                if (finish) begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // controller outputs
    always_comb begin
        s_ready = 1'b0;
        put_go  = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_SCAN: s_ready = 1'b0;
            ST_PUT:  put_go  = !m_valid_reg || m_ready;
            default: s_ready = 1'b0;
        endcase
    end

    // datapath next values
    always_comb begin
        launch_next   = in_acc && (s_data.command == CMD_ALLOC);
        req_next      = in_acc ? amt : req_reg;
        start_next    = start_reg;
        if (in_acc) begin
            start_next = (32'(next_ptr_reg) < 32'(count_reg)) ? next_ptr_reg : '0;
        end
        next_ptr_next = next_ptr_reg;
        if (finish && fin_found && (mode_reg == FIT_NEXT)) begin
            next_ptr_next = fin_idx;
        end
        res_next = res_reg;
        if (in_acc && (s_data.command == CMD_LOAD)) begin
            res_next.granted       = 1'b1;
            res_next.chosen_block  = s_data.block_index;
            res_next.left_in_block = 16'(amt);
        end else if (finish) begin
            if (fin_found) begin
                res_next.granted       = 1'b1;
                res_next.chosen_block  = 3'(fin_idx);
                res_next.left_in_block = 16'(left_full);
            end else begin
                res_next = '0;
            end
        end
        m_valid_next = put_go ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        m_data_next  = put_go ? res_reg : m_data_reg;
    end

    // config registers
    always_comb begin
        mode_next  = mode_reg;
        count_next = count_reg;
        if (cfg_wr) begin
            if (paddr[2] == REG_MODE) begin
                mode_next = pwdata[1:0];
            end else begin
                count_next = pwdata[3:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_COUNT) ? DATA_W'(count_reg) : DATA_W'(mode_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= FIT_FIRST;
            count_reg    <= COUNT_RESET;
            next_ptr_reg <= '0;
            launch_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            count_reg    <= count_next;
            next_ptr_reg <= next_ptr_next;
            launch_reg   <= launch_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        start_reg  <= start_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // head of the chain
    assign flag_c[0] = '{tok: launch_reg, found: 1'b0, ahead: 1'b0};
    assign idx_c[0]  = '0;
    assign size_c[0] = '0;

    for (genvar i = 0; i < BLOCKS; i++) begin : g_cell
        assign use_mask[i] = 32'(i) < 32'(count_reg);
        assign wr_en[i] = (in_acc && (s_data.command == CMD_LOAD)
                              && (32'(s_data.block_index) == 32'(i)))
                       || (finish && fin_found && (fin_idx == IDX_W'(i)));

        fab_cell #(
            .BLOCKS    (BLOCKS),
            .SIZE_BITS (SIZE_BITS),
            .CELL_IDX  (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .mode      (mode_reg),
            .start     (start_reg),
            .in_use    (use_mask[i]),
            .req       (req_reg),
            .wr_en     (wr_en[i]),
            .wr_data   (wr_data),
            .flags_in  (flag_c[i]),
            .idx_in    (idx_c[i]),
            .size_in   (size_c[i]),
            .flags_out (flag_c[i+1]),
            .idx_out   (idx_c[i+1]),
            .size_out  (size_c[i+1])
        );
    end

endmodule

@@ hdl/fab_checker.sv @@
// fab_checker: port-level checks for fit_block_allocator
// bound to the top level; depends on fab_pkg
`timescale 1ns / 1ps

module fab_checker
    import fab_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input fab_rsp_t          m_data
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one request in flight
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    // refusal carries zero fields
    a_refuse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.granted |->
            (m_data.chosen_block == 3'd0) && (m_data.left_in_block == 16'd0))
        else $error("refused result not zero");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind fit_block_allocator fab_checker u_fab_checker (.*);
